### hw/rtl/smms_pkg.sv
// Shared types, constants and codes of the scan-to-map match scorer.
package smms_pkg;

	// Map and scan geometry
	localparam int MAP_SIDE        = 512;
	localparam int MAX_SCAN_POINTS = 4096;
	localparam int COORD_FRAC_BITS = 20;
	localparam int MAP_DEPTH       = MAP_SIDE * MAP_SIDE;
	localparam int MAP_AW          = $clog2(MAP_DEPTH);
	localparam int SIDE_W          = $clog2(MAP_SIDE) + 1;
	localparam int COORD_W         = $clog2(MAP_SIDE);
	localparam int PS_W            = $clog2(MAX_SCAN_POINTS) + 1;

	// Field widths
	localparam int ADDR_W   = 18;
	localparam int PIX_W    = 16;
	localparam int MM_W     = 16;
	localparam int TRIG_W   = 24;
	localparam int OFF_W    = 36;
	localparam int CFG_W    = 36;
	localparam int CFG_IX_W = 3;
	localparam int SCORE_W  = 27;

	// Datapath widths
	localparam int PROD_W = TRIG_W + MM_W;
	localparam int ROT_W  = PROD_W + 1;
	localparam int FX_W   = ROT_W + 1;
	localparam int X_W    = FX_W - COORD_FRAC_BITS;
	localparam logic signed [FX_W-1:0] HALF_PIX = FX_W'(1) <<< (COORD_FRAC_BITS - 1);

	// Accumulators and divider
	localparam int SUM_W       = 29;
	localparam int CNT_W       = 13;
	localparam int SCALE_SHIFT = 10;
	localparam int QUO_W       = SCORE_W - 1;
	localparam int DIVD_W      = SUM_W + SCALE_SHIFT;
	localparam int STEP_W      = $clog2(QUO_W);

	typedef enum logic [CFG_IX_W-1:0] {
		CFG_COS,
		CFG_SIN,
		CFG_OFFX,
		CFG_OFFY,
		CFG_SIDE,
		CFG_OBST
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_scaled;
		logic signed [TRIG_W-1:0] sin_scaled;
		logic signed [OFF_W-1:0]  offset_x;
		logic signed [OFF_W-1:0]  offset_y;
		logic [SIDE_W-1:0]        map_side;
		logic [PIX_W-1:0]         obstacle_value;
	} cfg_t;

	// One classified transaction on its way from front to back
	typedef struct packed {
		logic                   wr;
		logic                   use_pt;
		logic                   last;
		logic [ADDR_W-1:0]      map_address;
		logic [PIX_W-1:0]       map_value;
		logic signed [MM_W-1:0] px;
		logic signed [MM_W-1:0] py;
	} item_t;

	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} div_req_t;

endpackage

### hw/rtl/smms_front.sv
// Front end: accepts transactions, classifies them and counts scan points.
module smms_front import smms_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   q_full,
	input  cfg_t                   cfg,
	input  logic                   req_type,
	input  logic [ADDR_W-1:0]      map_address,
	input  logic [PIX_W-1:0]       map_value,
	input  logic signed [MM_W-1:0] point_x_mm,
	input  logic signed [MM_W-1:0] point_y_mm,
	input  logic [PIX_W-1:0]       point_value,
	input  logic                   last,
	output logic                   q_push,
	output item_t                  q_item
);

	logic [PS_W-1:0] points_seen_q;
	logic            accept;
	logic            under_limit;

	assign accept      = push && !q_full;
	assign under_limit = points_seen_q < PS_W'(MAX_SCAN_POINTS);

	always_comb begin
		q_item.wr          = !req_type && ({1'b0, map_address} < (ADDR_W + 1)'(MAP_DEPTH));
		q_item.use_pt      = req_type && under_limit && (point_value == cfg.obstacle_value);
		q_item.last        = req_type && last;
		q_item.map_address = map_address;
		q_item.map_value   = map_value;
		q_item.px          = point_x_mm;
		q_item.py          = point_y_mm;
		// points that neither write, count nor close a scan are dropped here
		q_push = accept && (q_item.wr || q_item.use_pt || q_item.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_seen_q <= '0;
		end else if (accept && req_type) begin
			if (last)
				points_seen_q <= '0;
			else if (under_limit)
				points_seen_q <= points_seen_q + PS_W'(1);
		end
	end

endmodule

### hw/rtl/smms_fifo.sv
// Short queue of classified transactions between front and back.
module smms_fifo import smms_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  full,
	output logic  empty
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	item_t            store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = count_q == (PTR_W + 1)'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_item = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			store_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + (PTR_W + 1)'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - (PTR_W + 1)'(1);
		end
	end

endmodule

### hw/rtl/smms_back.sv
// Back end: point transform pipeline, map memory and scan accumulators.
module smms_back import smms_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_empty,
	input  item_t    q_item,
	output logic     q_pop,
	input  logic     div_busy,
	output div_req_t div_req
);

	// s1: products
	logic                     v_s1, wr_s1, use_s1, last_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic [PIX_W-1:0]         val_s1;
	logic signed [PROD_W-1:0] cpx_s1, spy_s1, spx_s1, cpy_s1;
	// s2: rotated coordinates
	logic                     v_s2, wr_s2, use_s2, last_s2;
	logic [ADDR_W-1:0]        addr_s2;
	logic [PIX_W-1:0]         val_s2;
	logic signed [ROT_W-1:0]  rx_s2, ry_s2;
	// s3: pixel coordinates and bounds
	logic                     v_s3, wr_s3, use_s3, last_s3, in_s3;
	logic [ADDR_W-1:0]        addr_s3;
	logic [PIX_W-1:0]         val_s3;
	logic [COORD_W-1:0]       x_s3, y_s3;
	// s4: flat index
	logic                     v_s4, wr_s4, hit_s4, last_s4;
	logic [ADDR_W-1:0]        addr_s4;
	logic [PIX_W-1:0]         val_s4;
	logic [MAP_AW-1:0]        idx_s4;
	// s5: pixel read back
	logic                     v_s5, hit_s5, last_s5;
	logic [PIX_W-1:0]         pix_s5;

	logic [PIX_W-1:0]         map_mem [MAP_DEPTH];
	logic [SUM_W-1:0]         sum_q, sum_nx;
	logic [CNT_W-1:0]         cnt_q, cnt_nx;

	logic                     last_busy;
	logic signed [FX_W-1:0]   fx, fy;
	logic signed [X_W-1:0]    xi, yi;
	logic [SIDE_W-1:0]        side_eff;
	logic                     x_in, y_in;
	logic [COORD_W+SIDE_W-1:0] row_base;
	logic                     hit5;

	// a scan end waits until no other one is in flight and the divider is free
	assign last_busy = v_s1 && last_s1 || v_s2 && last_s2 || v_s3 && last_s3 ||
		v_s4 && last_s4 || v_s5 && last_s5 || div_busy;
	assign q_pop = !q_empty && (!q_item.last || !last_busy);

	assign side_eff = (cfg.map_side > SIDE_W'(MAP_SIDE)) ? SIDE_W'(MAP_SIDE) : cfg.map_side;

	always_comb begin
		fx   = FX_W'(rx_s2) + FX_W'(cfg.offset_x) + HALF_PIX;
		fy   = FX_W'(ry_s2) + FX_W'(cfg.offset_y) + HALF_PIX;
		xi   = fx[FX_W-1:COORD_FRAC_BITS];
		yi   = fy[FX_W-1:COORD_FRAC_BITS];
		x_in = !xi[X_W-1] && (xi < X_W'(side_eff));
		y_in = !yi[X_W-1] && (yi < X_W'(side_eff));
		row_base = (COORD_W + SIDE_W)'(y_s3) * (COORD_W + SIDE_W)'(side_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		wr_s1   <= q_item.wr;
		use_s1  <= q_item.use_pt;
		last_s1 <= q_item.last;
		addr_s1 <= q_item.map_address;
		val_s1  <= q_item.map_value;
		cpx_s1  <= PROD_W'(cfg.cos_scaled) * PROD_W'(q_item.px);
		spy_s1  <= PROD_W'(cfg.sin_scaled) * PROD_W'(q_item.py);
		spx_s1  <= PROD_W'(cfg.sin_scaled) * PROD_W'(q_item.px);
		cpy_s1  <= PROD_W'(cfg.cos_scaled) * PROD_W'(q_item.py);

		wr_s2   <= wr_s1;
		use_s2  <= use_s1;
		last_s2 <= last_s1;
		addr_s2 <= addr_s1;
		val_s2  <= val_s1;
		rx_s2   <= ROT_W'(cpx_s1) - ROT_W'(spy_s1);
		ry_s2   <= ROT_W'(spx_s1) + ROT_W'(cpy_s1);

		wr_s3   <= wr_s2;
		use_s3  <= use_s2;
		last_s3 <= last_s2;
		addr_s3 <= addr_s2;
		val_s3  <= val_s2;
		in_s3   <= x_in && y_in;
		x_s3    <= xi[COORD_W-1:0];
		y_s3    <= yi[COORD_W-1:0];

		wr_s4   <= wr_s3;
		hit_s4  <= use_s3 && in_s3;
		last_s4 <= last_s3;
		addr_s4 <= addr_s3;
		val_s4  <= val_s3;
		idx_s4  <= MAP_AW'(row_base + (COORD_W + SIDE_W)'(x_s3));

		hit_s5  <= hit_s4;
		last_s5 <= last_s4;
	end

	// map store, one write and one lookup a cycle: both sit in this stage, so order holds
	always_ff @(posedge clk) begin
		if (v_s4 && wr_s4)
			map_mem[addr_s4[MAP_AW-1:0]] <= val_s4;
		pix_s5 <= map_mem[idx_s4];
	end

	assign hit5   = v_s5 && hit_s5;
	assign sum_nx = sum_q + (hit5 ? SUM_W'(pix_s5) : SUM_W'(0));
	assign cnt_nx = cnt_q + (hit5 ? CNT_W'(1) : CNT_W'(0));

	always_comb begin
		div_req.valid = v_s5 && last_s5;
		div_req.sum   = sum_nx;
		div_req.cnt   = cnt_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (v_s5 && last_s5) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (hit5) begin
			sum_q <= sum_nx;
			cnt_q <= cnt_nx;
		end
	end

endmodule

### hw/rtl/smms_div.sv
// Score divider: restoring long division of sum*1024 by count, with result slot.
module smms_div import smms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  div_req_t                  req,
	input  logic                      pop,
	output logic                      empty,
	output logic signed [SCORE_W-1:0] score,
	output logic                      busy
);

	div_state_t         state_q, state_nx;
	logic [CNT_W-1:0]   rem_q, divisor_q, rem_nx;
	logic [QUO_W-1:0]   sh_q, sh_nx;
	logic [STEP_W-1:0]  step_q;
	logic [SCORE_W-1:0] score_q;
	logic [CNT_W:0]     trial;
	logic               ge;
	logic [DIVD_W-1:0]  dividend;

	assign dividend = {req.sum, SCALE_SHIFT'(0)};
	assign trial    = {rem_q, sh_q[QUO_W-1]};
	assign ge       = trial >= {1'b0, divisor_q};
	assign rem_nx   = ge ? CNT_W'(trial - {1'b0, divisor_q}) : trial[CNT_W-1:0];
	assign sh_nx    = {sh_q[QUO_W-2:0], ge};

	assign score = score_q;
	assign empty = state_q != DIV_HOLD;
	assign busy  = state_q != DIV_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= DIV_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (req.valid)
					state_nx = (req.cnt == '0) ? DIV_HOLD : DIV_RUN;
			end
			DIV_RUN: begin
				if (step_q == STEP_W'(QUO_W - 1))
					state_nx = DIV_HOLD;
			end
			DIV_HOLD: begin
				if (pop)
					state_nx = DIV_IDLE;
			end
			default: state_nx = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				// quotient fits QUO_W bits, so the top bits start below the divisor
				rem_q     <= dividend[DIVD_W-1:QUO_W];
				sh_q      <= dividend[QUO_W-1:0];
				divisor_q <= req.cnt;
				step_q    <= '0;
				score_q   <= '1;
			end
			DIV_RUN: begin
				rem_q  <= rem_nx;
				sh_q   <= sh_nx;
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(QUO_W - 1))
					score_q <= {1'b0, sh_nx};
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

endmodule

### hw/rtl/scan_to_map_match_score.sv
// Top level of the scan-to-map match scorer: registers, front, queue, back, divider.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  request   | push / full        | req_type, map_address, map_value, point_x_mm,
//            |                    | point_y_mm, point_value, last
//  score     | empty / pop        | score (27-bit signed)
//  config    | cfg_we (no wait)   | cfg_index, cfg_data
//
//  Map writes and scan points go in at one transaction per clock while the
//  queue is not full; each point passes through transform stages s1 to s5
//  before its pixel is summed. The point that closes a scan is held back at
//  the queue head until the previous score has been popped; its score then
//  takes a load step and the bit-serial divider (one quotient bit a cycle),
//  or just the load step with no match.
//  Reset clears control state and registers only; map pixels are undefined
//  until written. The queue decouples the front from stalls in the back.
module scan_to_map_match_score import smms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// requests
	input  logic                      push,
	output logic                      full,
	input  logic                      req_type,
	input  logic [ADDR_W-1:0]         map_address,
	input  logic [PIX_W-1:0]          map_value,
	input  logic signed [MM_W-1:0]    point_x_mm,
	input  logic signed [MM_W-1:0]    point_y_mm,
	input  logic [PIX_W-1:0]          point_value,
	input  logic                      last,
	// scores
	output logic                      empty,
	input  logic                      pop,
	output logic signed [SCORE_W-1:0] score,
	// configuration
	input  logic                      cfg_we,
	input  logic [CFG_IX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	cfg_t     cfg_q;
	logic     q_push, q_pop, q_full, q_empty;
	item_t    q_in, q_out;
	logic     div_busy;
	div_req_t div_req;

	// Register file; indices past the last register are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_scaled     <= '0;
			cfg_q.sin_scaled     <= '0;
			cfg_q.offset_x       <= '0;
			cfg_q.offset_y       <= '0;
			cfg_q.map_side       <= SIDE_W'(MAP_SIDE);
			cfg_q.obstacle_value <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COS:  cfg_q.cos_scaled     <= cfg_data[TRIG_W-1:0];
				CFG_SIN:  cfg_q.sin_scaled     <= cfg_data[TRIG_W-1:0];
				CFG_OFFX: cfg_q.offset_x       <= cfg_data[OFF_W-1:0];
				CFG_OFFY: cfg_q.offset_y       <= cfg_data[OFF_W-1:0];
				CFG_SIDE: cfg_q.map_side       <= cfg_data[SIDE_W-1:0];
				CFG_OBST: cfg_q.obstacle_value <= cfg_data[PIX_W-1:0];
				default:  cfg_q <= cfg_q;
			endcase
		end
	end

	// The front only stalls on a full queue
	assign full = q_full;

	smms_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.q_full      (q_full),
		.cfg         (cfg_q),
		.req_type    (req_type),
		.map_address (map_address),
		.map_value   (map_value),
		.point_x_mm  (point_x_mm),
		.point_y_mm  (point_y_mm),
		.point_value (point_value),
		.last        (last),
		.q_push      (q_push),
		.q_item      (q_in)
	);

	smms_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_in),
		.rd_en   (q_pop),
		.rd_item (q_out),
		.full    (q_full),
		.empty   (q_empty)
	);

	smms_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_item   (q_out),
		.q_pop    (q_pop),
		.div_busy (div_busy),
		.div_req  (div_req)
	);

	smms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.pop    (pop),
		.empty  (empty),
		.score  (score),
		.busy   (div_busy)
	);

	// A scan may only close while the divider and score slot are free
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.valid |-> !div_busy)
		else $error("scan closed while divider busy");

	// Queue is never popped empty nor written full
	a_queue_safe: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty) && !(q_push && q_full))
		else $error("queue over- or underflow");

	// A shown score is either no-match or a mean within the pixel range
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (score == '1 || (!score[SCORE_W-1] && score <= 27'sd67107840)))
		else $error("score out of range");

	// Score stays put until taken
	a_score_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(score))
		else $error("score lost before pop");

endmodule
